/* hw/rtl/pixel_mask_collision_test_defines.svh */
`ifndef PIXEL_MASK_COLLISION_TEST_DEFINES_SVH
`define PIXEL_MASK_COLLISION_TEST_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PMCT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define PMCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/pmct_pkg.sv */
`timescale 1ns / 1ps

package pmct_pkg;

    localparam int MASK_W_DEF    = 64;
    localparam int MASK_H_DEF    = 64;
    localparam int NUM_SLOTS_DEF = 8;

    // Field width of positions and sizes, and the wider geometry width.
    localparam int FW = 12;
    localparam int CW = 14;

    localparam logic [1:0] ACT_MASK  = 2'd0;
    localparam logic [1:0] ACT_RECT  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic [1:0]    action;
        logic          sprite_sel;
        logic [2:0]    slot_a;
        logic [2:0]    slot_b;
        logic [FW-1:0] pos_x;
        logic [FW-1:0] pos_y;
        logic [FW-1:0] rect_w;
        logic [FW-1:0] rect_h;
        logic          mask_bit;
        logic          pixel_exact;
    } item_t;

    typedef struct packed {
        logic bad_slot;
        logic hit;
    } res_t;

    typedef struct packed {
        logic [FW-1:0] h;
        logic [FW-1:0] w;
        logic [FW-1:0] y;
        logic [FW-1:0] x;
    } rect_t;

    typedef struct packed {
        logic done;
        logic hit;
    } walk_stat_t;

    function automatic coord_t sx(input logic [FW-1:0] v);
        return {{(CW-FW){v[FW-1]}}, v};
    endfunction

    function automatic coord_t zx(input logic [FW-1:0] v);
        return {{(CW-FW){1'b0}}, v};
    endfunction

    function automatic coord_t cmax(input coord_t a, input coord_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic coord_t cmin(input coord_t a, input coord_t b);
        return (a < b) ? a : b;
    endfunction

endpackage

/* hw/rtl/pixel_mask_collision_test.sv */
// A rectangle write or refused query goes from dispatch to the result; a mask write passes
// ST_MADR and ST_MWR; a rectangle-mode query reads rectangles and runs ST_GEO1 and ST_GEO2;
// a pixel-exact query also runs ST_GEO3, ST_GEO4, ST_ADR0 and ST_ADR1, then walks mask pixel
// pairs (up to MASK_W * MASK_H, 4096 by default), the walker reading one bit of each mask RAM
// per cycle; one with nothing to walk ends in the geometry states. One beat is in work at a
// time; a result waits until the output register is free. Reset: synchronous, active low;
// both masks are then swept clear over all addresses, one a cycle, with s_tready held low.
`timescale 1ns / 1ps

module pixel_mask_collision_test import pmct_pkg::*; #(
    parameter int MASK_W    = MASK_W_DEF,
    parameter int MASK_H    = MASK_H_DEF,
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input beat.
    input  logic        s_tvalid,
    output logic        s_tready,
    // slot_a[2:0], slot_b[5:3], pos_x[17:6], pos_y[29:18], rect_w[41:30],
    // rect_h[53:42], mask_bit[54], pixel_exact[55]
    input  logic [55:0] s_tdata,
    // action[1:0], sprite_sel[2]
    input  logic [2:0]  s_tuser,
    // Result beat.
    output logic        m_tvalid,
    input  logic        m_tready,
    // hit[0], bad_slot[1], zero above
    output logic [7:0]  m_tdata
);

    item_t      item;
    logic       core_ready, take, out_free, res_valid;
    res_t       res;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;

    // Unpack the beat into the item fields.
    assign item.action      = s_tuser[1:0];
    assign item.sprite_sel  = s_tuser[2];
    assign item.slot_a      = s_tdata[2:0];
    assign item.slot_b      = s_tdata[5:3];
    assign item.pos_x       = s_tdata[17:6];
    assign item.pos_y       = s_tdata[29:18];
    assign item.rect_w      = s_tdata[41:30];
    assign item.rect_h      = s_tdata[53:42];
    assign item.mask_bit    = s_tdata[54];
    assign item.pixel_exact = s_tdata[55];

    // Take a beat only while the sequencer sits idle; the output register
    // decouples it from the result side.
    assign s_tready = core_ready;
    assign take     = s_tvalid & core_ready;

    // The core may hand over a result when the output register is empty or
    // being drained this cycle.
    assign out_free = ~m_tvalid_reg | m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid) begin
            // Load a fresh result.
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'b0, res.bad_slot, res.hit};
        end else if (m_tready) begin
            // Drop the result once the sink has taken it.
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    pmct_core #(
        .MASK_W    (MASK_W),
        .MASK_H    (MASK_H),
        .NUM_SLOTS (NUM_SLOTS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .item_in   (item),
        .ready     (core_ready),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

/* hw/rtl/pmct_ram.sv */
`timescale 1ns / 1ps

module pmct_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/pmct_walk.sv */
`timescale 1ns / 1ps

module pmct_walk import pmct_pkg::*; #(
    parameter int MASK_W = MASK_W_DEF,
    parameter int MASK_H = MASK_H_DEF,
    localparam int AW = $clog2(MASK_W * MASK_H),
    localparam int XW = $clog2(MASK_W),
    localparam int YW = $clog2(MASK_H)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [AW-1:0] start_a0,
    input  logic [AW-1:0] start_a1,
    input  logic [XW-1:0] x_last,
    input  logic [YW-1:0] y_last,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr0,
    output logic [AW-1:0] rd_addr1,
    input  logic          rd_bit0,
    input  logic          rd_bit1,
    output walk_stat_t    stat
);

    localparam logic [AW-1:0] ROW_STEP = AW'(MASK_W);

    logic          active_reg, active_next;
    logic          pend_reg, pend_next;
    logic          last_reg, last_next;
    logic [AW-1:0] a0_reg, a0_next, a1_reg, a1_next;
    logic [AW-1:0] row0_reg, row0_next, row1_reg, row1_next;
    logic [XW-1:0] xc_reg, xc_next, xl_reg, xl_next;
    logic [YW-1:0] yc_reg, yc_next, yl_reg, yl_next;
    logic          hit_now, done, is_last;

    assign hit_now  = pend_reg & rd_bit0 & rd_bit1;
    assign done     = pend_reg & (hit_now | last_reg);
    assign is_last  = (xc_reg == xl_reg) && (yc_reg == yl_reg);
    assign rd_en    = active_reg & ~done;
    assign rd_addr0 = a0_reg;
    assign rd_addr1 = a1_reg;
    assign stat     = '{done: done, hit: hit_now};

    always_comb begin
        active_next = active_reg;
        pend_next   = 1'b0;
        last_next   = last_reg;
        a0_next     = a0_reg;
        a1_next     = a1_reg;
        row0_next   = row0_reg;
        row1_next   = row1_reg;
        xc_next     = xc_reg;
        yc_next     = yc_reg;
        xl_next     = xl_reg;
        yl_next     = yl_reg;
        if (start) begin
            active_next = 1'b1;
            last_next   = 1'b0;
            a0_next     = start_a0;
            a1_next     = start_a1;
            row0_next   = start_a0;
            row1_next   = start_a1;
            xc_next     = '0;
            yc_next     = '0;
            xl_next     = x_last;
            yl_next     = y_last;
        end else if (rd_en) begin
            // Issue one pixel pair, then step along the row or wrap to the next.
            pend_next   = 1'b1;
            last_next   = is_last;
            active_next = ~is_last;
            if (xc_reg == xl_reg) begin
                xc_next   = '0;
                yc_next   = yc_reg + 1'b1;
                row0_next = row0_reg + ROW_STEP;
                row1_next = row1_reg + ROW_STEP;
                a0_next   = row0_reg + ROW_STEP;
                a1_next   = row1_reg + ROW_STEP;
            end else begin
                xc_next = xc_reg + 1'b1;
                a0_next = a0_reg + 1'b1;
                a1_next = a1_reg + 1'b1;
            end
        end else if (done) begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            pend_reg   <= 1'b0;
            last_reg   <= 1'b0;
        end else begin
            active_reg <= active_next;
            pend_reg   <= pend_next;
            last_reg   <= last_next;
        end
        a0_reg   <= a0_next;
        a1_reg   <= a1_next;
        row0_reg <= row0_next;
        row1_reg <= row1_next;
        xc_reg   <= xc_next;
        yc_reg   <= yc_next;
        xl_reg   <= xl_next;
        yl_reg   <= yl_next;
    end

endmodule

/* hw/rtl/pmct_core.sv */
`timescale 1ns / 1ps
`include "pixel_mask_collision_test_defines.svh"

module pmct_core import pmct_pkg::*; #(
    parameter int MASK_W    = MASK_W_DEF,
    parameter int MASK_H    = MASK_H_DEF,
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    localparam int MDEPTH = MASK_W * MASK_H,
    localparam int AW     = $clog2(MDEPTH),
    localparam int XW     = $clog2(MASK_W),
    localparam int YW     = $clog2(MASK_H),
    localparam int SW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    localparam int RDEPTH = 2 * (1 << SW)
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  take,
    input  item_t item_in,
    output logic  ready,
    input  logic  out_free,
    output logic  res_valid,
    output res_t  res
);

    localparam logic [4:0] ST_CLEAR = 5'd0;
    localparam logic [4:0] ST_IDLE  = 5'd1;
    localparam logic [4:0] ST_DISP  = 5'd2;
    localparam logic [4:0] ST_GETA  = 5'd3;
    localparam logic [4:0] ST_GETB  = 5'd4;
    localparam logic [4:0] ST_GETOA = 5'd5;
    localparam logic [4:0] ST_GETOB = 5'd6;
    localparam logic [4:0] ST_GEO1  = 5'd7;
    localparam logic [4:0] ST_GEO2  = 5'd8;
    localparam logic [4:0] ST_GEO3  = 5'd9;
    localparam logic [4:0] ST_GEO4  = 5'd10;
    localparam logic [4:0] ST_ADR0  = 5'd11;
    localparam logic [4:0] ST_ADR1  = 5'd12;
    localparam logic [4:0] ST_WALK  = 5'd13;
    localparam logic [4:0] ST_MADR  = 5'd14;
    localparam logic [4:0] ST_MWR   = 5'd15;
    localparam logic [4:0] ST_DONE  = 5'd16;

    localparam logic [AW-1:0] CLR_LAST = AW'(MDEPTH - 1);
    localparam coord_t        MW_C     = coord_t'(MASK_W);
    localparam coord_t        MH_C     = coord_t'(MASK_H);
    localparam int            RECT_BITS = $bits(rect_t);

    logic [4:0]   state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    item_t        item_reg, item_next;
    res_t         res_reg, res_next;
    logic [1:0][NUM_SLOTS-1:0] valid_reg, valid_next;

    rect_t  ra_reg, ra_next, rb_reg, rb_next, oa_reg, oa_next, ob_reg, ob_next;
    coord_t ix0_reg, ix0_next, ix1_reg, ix1_next, iy0_reg, iy0_next, iy1_reg, iy1_next;
    logic   empty_reg, empty_next;
    coord_t wd_reg, wd_next, ht_reg, ht_next;
    coord_t ax_reg, ax_next, ay_reg, ay_next, bx_reg, bx_next, by_reg, by_next;
    coord_t xlo_reg, xlo_next, xhi_reg, xhi_next, ylo_reg, ylo_next, yhi_reg, yhi_next;
    logic [XW-1:0] m0x_reg, m0x_next, m1x_reg, m1x_next, xlast_reg, xlast_next;
    logic [YW-1:0] m0y_reg, m0y_next, m1y_reg, m1y_next, ylast_reg, ylast_next;
    logic [AW-1:0] a0_reg, a0_next;
    logic          wok_reg, wok_next;

    // Slot decode.
    logic [4:0]    sa_ext, sb_ext;
    logic          sa_ok, sb_ok, q_bad;
    logic [SW-1:0] sa_idx, sb_idx;

    // Geometry intermediates.
    coord_t wd_calc, ht_calc, sum0x, sum0y, sum1x, sum1y, xspan, yspan, px_c, py_c;

    // Shared address unit: row times mask width plus column.
    logic [XW-1:0] mul_x;
    logic [YW-1:0] mul_y;
    logic [AW-1:0] addr_calc;

    // Rectangle store.
    logic                 rect_we, rect_re;
    logic [SW:0]          rect_waddr, rect_raddr;
    logic [RECT_BITS-1:0] rect_rdata;
    rect_t                rect_rd;

    // Mask stores and walker.
    logic          mask_we0, mask_we1, mask_wdata;
    logic [AW-1:0] mask_waddr;
    logic          walk_start, walk_rd_en, rd_bit0, rd_bit1;
    logic [AW-1:0] walk_addr0, walk_addr1;
    walk_stat_t    walk_stat;

    assign sa_ext = 5'(item_reg.slot_a);
    assign sb_ext = 5'(item_reg.slot_b);
    assign sa_ok  = sa_ext < 5'(NUM_SLOTS);
    assign sb_ok  = sb_ext < 5'(NUM_SLOTS);
    assign sa_idx = sa_ext[SW-1:0];
    assign sb_idx = sb_ext[SW-1:0];
    assign q_bad  = !(sa_ok && valid_reg[0][sa_idx]) || !(sb_ok && valid_reg[1][sb_idx])
                    || !valid_reg[0][0] || !valid_reg[1][0];

    assign wd_calc = ix1_reg - ix0_reg;
    assign ht_calc = iy1_reg - iy0_reg;
    assign sum0x   = ax_reg + xlo_reg;
    assign sum0y   = ay_reg + ylo_reg;
    assign sum1x   = bx_reg + xlo_reg;
    assign sum1y   = by_reg + ylo_reg;
    assign xspan   = xhi_reg - xlo_reg - coord_t'(1);
    assign yspan   = yhi_reg - ylo_reg - coord_t'(1);
    assign px_c    = sx(item_reg.pos_x);
    assign py_c    = sx(item_reg.pos_y);

    always_comb begin
        if (state_reg == ST_MADR) begin
            mul_x = item_reg.pos_x[XW-1:0];
            mul_y = item_reg.pos_y[YW-1:0];
        end else if (state_reg == ST_ADR1) begin
            mul_x = m1x_reg;
            mul_y = m1y_reg;
        end else begin
            mul_x = m0x_reg;
            mul_y = m0y_reg;
        end
    end

    assign addr_calc = AW'(mul_y) * AW'(MASK_W) + AW'(mul_x);

    assign rect_rd    = rect_t'(rect_rdata);
    assign rect_waddr = {item_reg.sprite_sel, sa_idx};

    assign mask_waddr = (state_reg == ST_CLEAR) ? clr_reg : a0_reg;
    assign mask_wdata = (state_reg == ST_CLEAR) ? 1'b0 : item_reg.mask_bit;
    assign mask_we0   = (state_reg == ST_CLEAR)
                        || (state_reg == ST_MWR && wok_reg && !item_reg.sprite_sel);
    assign mask_we1   = (state_reg == ST_CLEAR)
                        || (state_reg == ST_MWR && wok_reg && item_reg.sprite_sel);

    assign ready = (state_reg == ST_IDLE);
    assign res   = res_reg;

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        valid_next = valid_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        oa_next    = oa_reg;
        ob_next    = ob_reg;
        ix0_next   = ix0_reg;
        ix1_next   = ix1_reg;
        iy0_next   = iy0_reg;
        iy1_next   = iy1_reg;
        empty_next = empty_reg;
        wd_next    = wd_reg;
        ht_next    = ht_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        xlo_next   = xlo_reg;
        xhi_next   = xhi_reg;
        ylo_next   = ylo_reg;
        yhi_next   = yhi_reg;
        m0x_next   = m0x_reg;
        m0y_next   = m0y_reg;
        m1x_next   = m1x_reg;
        m1y_next   = m1y_reg;
        xlast_next = xlast_reg;
        ylast_next = ylast_reg;
        a0_next    = a0_reg;
        wok_next   = wok_reg;
        rect_we    = 1'b0;
        rect_re    = 1'b0;
        rect_raddr = {1'b0, sa_idx};
        walk_start = 1'b0;
        res_valid  = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (take) begin
                    item_next  = item_in;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                res_next   = '0;
                state_next = ST_DONE;
                unique case (item_reg.action)
                    ACT_MASK: begin
                        state_next = ST_MADR;
                    end
                    ACT_RECT: begin
                        if (sa_ok) begin
                            rect_we = 1'b1;
                            valid_next[item_reg.sprite_sel][sa_idx] = 1'b1;
                        end
                    end
                    ACT_QUERY: begin
                        if (q_bad) begin
                            res_next.bad_slot = 1'b1;
                        end else begin
                            rect_re    = 1'b1;
                            rect_raddr = {1'b0, sa_idx};
                            state_next = ST_GETA;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_GETA: begin
                ra_next    = rect_rd;
                rect_re    = 1'b1;
                rect_raddr = {1'b1, sb_idx};
                state_next = ST_GETB;
            end
            ST_GETB: begin
                rb_next    = rect_rd;
                rect_re    = 1'b1;
                rect_raddr = {1'b0, {SW{1'b0}}};
                state_next = ST_GETOA;
            end
            ST_GETOA: begin
                oa_next    = rect_rd;
                rect_re    = 1'b1;
                rect_raddr = {1'b1, {SW{1'b0}}};
                state_next = ST_GETOB;
            end
            ST_GETOB: begin
                ob_next    = rect_rd;
                state_next = ST_GEO1;
            end
            ST_GEO1: begin
                ix0_next   = cmax(sx(ra_reg.x), sx(rb_reg.x));
                iy0_next   = cmax(sx(ra_reg.y), sx(rb_reg.y));
                ix1_next   = cmin(sx(ra_reg.x) + zx(ra_reg.w), sx(rb_reg.x) + zx(rb_reg.w));
                iy1_next   = cmin(sx(ra_reg.y) + zx(ra_reg.h), sx(rb_reg.y) + zx(rb_reg.h));
                empty_next = (ra_reg.w == '0) || (ra_reg.h == '0)
                             || (rb_reg.w == '0) || (rb_reg.h == '0);
                state_next = ST_GEO2;
            end
            ST_GEO2: begin
                wd_next = wd_calc;
                ht_next = ht_calc;
                ax_next = ix0_reg - sx(oa_reg.x);
                ay_next = iy0_reg - sx(oa_reg.y);
                bx_next = ix0_reg - sx(ob_reg.x);
                by_next = iy0_reg - sx(ob_reg.y);
                if (empty_reg || wd_calc <= 0 || ht_calc <= 0) begin
                    state_next = ST_DONE;
                end else if (!item_reg.pixel_exact) begin
                    res_next.hit = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    state_next = ST_GEO3;
                end
            end
            ST_GEO3: begin
                xlo_next   = cmax(coord_t'(0), cmax(-ax_reg, -bx_reg));
                ylo_next   = cmax(coord_t'(0), cmax(-ay_reg, -by_reg));
                xhi_next   = cmin(wd_reg, cmin(MW_C - ax_reg, MW_C - bx_reg));
                yhi_next   = cmin(ht_reg, cmin(MH_C - ay_reg, MH_C - by_reg));
                state_next = ST_GEO4;
            end
            ST_GEO4: begin
                m0x_next   = sum0x[XW-1:0];
                m0y_next   = sum0y[YW-1:0];
                m1x_next   = sum1x[XW-1:0];
                m1y_next   = sum1y[YW-1:0];
                xlast_next = xspan[XW-1:0];
                ylast_next = yspan[YW-1:0];
                if (xlo_reg >= xhi_reg || ylo_reg >= yhi_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_ADR0;
                end
            end
            ST_ADR0: begin
                a0_next    = addr_calc;
                state_next = ST_ADR1;
            end
            ST_ADR1: begin
                walk_start = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (walk_stat.done) begin
                    res_next.hit = walk_stat.hit;
                    state_next   = ST_DONE;
                end
            end
            ST_MADR: begin
                a0_next    = addr_calc;
                wok_next   = (px_c >= 0) && (px_c < MW_C) && (py_c >= 0) && (py_c < MH_C);
                state_next = ST_MWR;
            end
            ST_MWR: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            valid_reg <= valid_next;
        end
        item_reg  <= item_next;
        res_reg   <= res_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        oa_reg    <= oa_next;
        ob_reg    <= ob_next;
        ix0_reg   <= ix0_next;
        ix1_reg   <= ix1_next;
        iy0_reg   <= iy0_next;
        iy1_reg   <= iy1_next;
        empty_reg <= empty_next;
        wd_reg    <= wd_next;
        ht_reg    <= ht_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        bx_reg    <= bx_next;
        by_reg    <= by_next;
        xlo_reg   <= xlo_next;
        xhi_reg   <= xhi_next;
        ylo_reg   <= ylo_next;
        yhi_reg   <= yhi_next;
        m0x_reg   <= m0x_next;
        m0y_reg   <= m0y_next;
        m1x_reg   <= m1x_next;
        m1y_reg   <= m1y_next;
        xlast_reg <= xlast_next;
        ylast_reg <= ylast_next;
        a0_reg    <= a0_next;
        wok_reg   <= wok_next;
    end

    pmct_ram #(.WIDTH(RECT_BITS), .DEPTH(RDEPTH)) u_rect_ram (
        .aclk  (aclk),
        .we    (rect_we),
        .waddr (rect_waddr),
        .wdata ({item_reg.rect_h, item_reg.rect_w, item_reg.pos_y, item_reg.pos_x}),
        .re    (rect_re),
        .raddr (rect_raddr),
        .rdata (rect_rdata)
    );

    pmct_ram #(.WIDTH(1), .DEPTH(MDEPTH)) u_mask0_ram (
        .aclk  (aclk),
        .we    (mask_we0),
        .waddr (mask_waddr),
        .wdata (mask_wdata),
        .re    (walk_rd_en),
        .raddr (walk_addr0),
        .rdata (rd_bit0)
    );

    pmct_ram #(.WIDTH(1), .DEPTH(MDEPTH)) u_mask1_ram (
        .aclk  (aclk),
        .we    (mask_we1),
        .waddr (mask_waddr),
        .wdata (mask_wdata),
        .re    (walk_rd_en),
        .raddr (walk_addr1),
        .rdata (rd_bit1)
    );

    pmct_walk #(.MASK_W(MASK_W), .MASK_H(MASK_H)) u_walk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (walk_start),
        .start_a0 (a0_reg),
        .start_a1 (addr_calc),
        .x_last   (xlast_reg),
        .y_last   (ylast_reg),
        .rd_en    (walk_rd_en),
        .rd_addr0 (walk_addr0),
        .rd_addr1 (walk_addr1),
        .rd_bit0  (rd_bit0),
        .rd_bit1  (rd_bit1),
        .stat     (walk_stat)
    );

    `PMCT_ASSERT_SAME(a_res_room, res_valid, out_free, "result raised with output register full")
    `PMCT_ASSERT_SAME(a_wr_rd_excl, mask_we0 || mask_we1, !walk_rd_en, "mask write during walk")
    `PMCT_ASSERT_SAME(a_walk_done, walk_stat.done, state_reg == ST_WALK, "walk ended outside walk")
    `PMCT_ASSERT_NEXT(a_take_disp, take, state_reg == ST_DISP, "accepted beat not dispatched")

endmodule
